@@ rtl/ftsch_pkg.sv @@
`default_nettype none

package ftsch_pkg;

   // Field widths
   localparam int TIME_W   = 63;
   localparam int ORD_W    = 64;
   localparam int RATE_W   = 20;
   localparam int LIMIT_W  = 8;
   localparam int CSR_W    = 20;
   localparam int ERR_W    = 2;

   // Divider geometry: quotient bits retired per cycle
   localparam int DIV_W          = 64;
   localparam int DIV_RADIX_BITS = 4;
   localparam int DIV_CYCLES     = DIV_W / DIV_RADIX_BITS;
   localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

   // Arithmetic constants
   localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
   // Largest whole-second count whose nanosecond offset still fits in 63 bits
   localparam logic [63:0] WHOLE_MAX  = 64'd9223372036;

   // Command codes
   localparam logic ACT_START   = 1'b0;
   localparam logic ACT_ADVANCE = 1'b1;

   // Error codes
   localparam logic [ERR_W-1:0] ERR_OK              = 2'd0;
   localparam logic [ERR_W-1:0] ERR_NOT_STARTED     = 2'd1;
   localparam logic [ERR_W-1:0] ERR_ALREADY_STARTED = 2'd2;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW        = 2'd3;

   // Register indexes
   localparam logic REG_TICK_RATE    = 1'b0;
   localparam logic REG_MAX_CATCH_UP = 1'b1;

   // Reset values of the registers
   localparam logic [RATE_W-1:0]  TICK_RATE_RESET    = 20'd30;
   localparam logic [LIMIT_W-1:0] MAX_CATCH_UP_RESET = 8'd5;

   typedef struct packed {
      logic              action;
      logic [TIME_W-1:0] now_ns;
   } req_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] ticks_due;
      logic               rebased;
      logic [TIME_W-1:0]  lateness_ns;
      logic [ERR_W-1:0]   error;
   } rsp_type;

   // Divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

@@ rtl/ftsch_div.sv @@
`default_nettype none

// Restoring divider, 64-bit dividend by 20-bit divisor, several quotient bits per cycle.
// Results hold until the next start.
module ftsch_div
   import ftsch_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIV_W-1:0]  dividend,
   input  wire logic [RATE_W-1:0] divisor,
   output logic [DIV_W-1:0]       quotient,
   output logic [RATE_W-1:0]      remainder,
   output div_stat_type           stat
);

   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [RATE_W-1:0]    rem_ff, rem_in;
   logic [RATE_W-1:0]    dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   // Radix steps for one cycle: shift in a dividend bit, subtract if it fits
   always_comb begin
      logic [RATE_W:0]   r;
      logic [DIV_W-1:0]  q;
      r = {1'b0, rem_ff};
      q = quo_ff;
      for (int i = 0; i < DIV_RADIX_BITS; i++) begin
         r = {r[RATE_W-1:0], q[DIV_W-1]};
         q = {q[DIV_W-2:0], 1'b0};
         if (r >= {1'b0, dsr_ff}) begin
            r    = r - {1'b0, dsr_ff};
            q[0] = 1'b1;
         end
      end
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = q;
         rem_in = r[RATE_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

@@ rtl/fixed_rate_tick_scheduler_core.sv @@
`default_nettype none

// Fixed-rate tick scheduler with a catch-up limit.
// req channel: one item per command, action (start or advance) and now_ns.
// rsp channel: exactly one item per command: ticks_due, rebased, lateness_ns, error.
// csr port: csr_wen writes csr_wdata into register csr_index (0 tick_rate,
// 1 max_catch_up); the user must see that they are written only while no
// command is in flight, and nothing in the block enforces this.
// A start or a rejected command goes through res_ff and the PUSH state into the
// rsp register, and the next command is taken once its result has moved there.
// An advance evaluates ticks_due+1 deadlines, each with two passes of the
// shared 64/20-bit divider at 4 quotient bits per cycle, two passes of the
// 32x30 multiplier, an offset add and a deadline add/compare. A rebase adds
// the REB state before PUSH.
// req_stall is high from acceptance until the result moves into the rsp
// register; a waiting result does not block the next command, but a finished
// one waits for the register to free up when rsp_stall holds it.
// Reset (synchronous, active high) clears the started flag, the schedule and
// the channels, and loads tick_rate 30 and max_catch_up 5.
module fixed_rate_tick_scheduler_core
   import ftsch_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data,
   input  wire logic             csr_wen,
   input  wire logic [0:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   // Sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_D1GO   = 4'd1;
   localparam logic [3:0] S_D1WAIT = 4'd2;
   localparam logic [3:0] S_MUL1   = 4'd3;
   localparam logic [3:0] S_D2GO   = 4'd4;
   localparam logic [3:0] S_D2WAIT = 4'd5;
   localparam logic [3:0] S_MUL2   = 4'd6;
   localparam logic [3:0] S_ADD    = 4'd7;
   localparam logic [3:0] S_CHK    = 4'd8;
   localparam logic [3:0] S_REB    = 4'd9;
   localparam logic [3:0] S_PUSH   = 4'd10;

   logic [3:0]          state_ff, state_in;
   logic                started_ff, started_in;
   logic [TIME_W-1:0]   epoch_ff, epoch_in;
   logic [ORD_W-1:0]    ordinal_ff, ordinal_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [LIMIT_W-1:0]  ticks_ff, ticks_in;
   logic                final_ff, final_in;
   logic [33:0]         whole_ff, whole_in;
   logic [29:0]         frac_ff, frac_in;
   logic [61:0]         prod_ff, prod_in;
   logic [63:0]         off_ff, off_in;
   logic [TIME_W-1:0]   deadline_ff, deadline_in;
   rsp_type             res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [RATE_W-1:0]   tick_rate_ff, tick_rate_in;
   logic [LIMIT_W-1:0]  max_catch_up_ff, max_catch_up_in;

   logic [RATE_W-1:0]   rate_eff;
   logic [LIMIT_W-1:0]  limit_eff;
   logic                div_start;
   logic [DIV_W-1:0]    div_dividend;
   logic [DIV_W-1:0]    div_quo;
   logic [RATE_W-1:0]   div_rem;
   div_stat_type        div_stat;
   logic [31:0]         mul_a;
   logic [61:0]         mul_prod;
   logic [31:0]         hi_ns;
   logic [64:0]         sum;
   logic                due;

   // Zero in a register means one
   assign rate_eff  = (tick_rate_ff == '0) ? RATE_W'(1) : tick_rate_ff;
   assign limit_eff = (max_catch_up_ff == '0) ? LIMIT_W'(1) : max_catch_up_ff;

   // Shared divider: ordinal / rate, then rem * 1e9 / rate
   assign div_start    = (state_ff == S_D1GO) || (state_ff == S_D2GO);
   assign div_dividend = (state_ff == S_D1GO) ? ordinal_ff : {14'b0, prod_ff[49:0]};

   ftsch_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (rate_eff),
      .quotient  (div_quo),
      .remainder (div_rem),
      .stat      (div_stat)
   );

   // Shared multiplier by 1e9
   assign mul_a    = (state_ff == S_MUL1) ? {12'b0, div_rem} : whole_ff[31:0];
   assign mul_prod = {30'b0, mul_a} * {32'b0, NS_PER_SEC};

   // Top two bits of the whole-second count times 1e9, placed above bit 32
   assign hi_ns = (whole_ff[33] ? {1'b0, NS_PER_SEC, 1'b0} : 32'd0)
                + (whole_ff[32] ? {2'b0, NS_PER_SEC} : 32'd0);

   // Deadline = epoch + offset, checked against the 63-bit time range
   assign sum = {2'b0, epoch_ff} + {1'b0, off_ff};
   assign due = (sum[TIME_W-1:0] <= now_ff);

   assign req_stall = (state_ff != S_IDLE);

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      started_in      = started_ff;
      epoch_in        = epoch_ff;
      ordinal_in      = ordinal_ff;
      now_in          = now_ff;
      ticks_in        = ticks_ff;
      final_in        = final_ff;
      whole_in        = whole_ff;
      frac_in         = frac_ff;
      prod_in         = prod_ff;
      off_in          = off_ff;
      deadline_in     = deadline_ff;
      res_in          = res_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      tick_rate_in    = tick_rate_ff;
      max_catch_up_in = max_catch_up_ff;

      // Register writes
      if (csr_wen) begin
         case (csr_index[0])
            REG_TICK_RATE:    tick_rate_in    = csr_wdata[RATE_W-1:0];
            REG_MAX_CATCH_UP: max_catch_up_in = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in = '{ticks_due: '0, rebased: 1'b0, lateness_ns: '0, error: ERR_OK};
               state_in = S_PUSH;
               if (req_data.action == ACT_START) begin
                  if (started_ff) begin
                     res_in.error = ERR_ALREADY_STARTED;
                  end else begin
                     started_in = 1'b1;
                     epoch_in   = req_data.now_ns;
                     ordinal_in = ORD_W'(1);
                  end
               end else if (!started_ff) begin
                  res_in.error = ERR_NOT_STARTED;
               end else begin
                  now_in   = req_data.now_ns;
                  ticks_in = '0;
                  final_in = 1'b0;
                  state_in = S_D1GO;
               end
            end
         end
         S_D1GO: begin
            state_in = S_D1WAIT;
         end
         S_D1WAIT: begin
            if (div_stat.done) begin
               if (div_quo > WHOLE_MAX) begin
                  res_in.error = ERR_OVERFLOW;
                  state_in     = S_PUSH;
               end else begin
                  whole_in = div_quo[33:0];
                  state_in = S_MUL1;
               end
            end
         end
         S_MUL1: begin
            prod_in  = mul_prod;
            state_in = S_D2GO;
         end
         S_D2GO: begin
            state_in = S_D2WAIT;
         end
         S_D2WAIT: begin
            if (div_stat.done) begin
               frac_in  = div_quo[29:0];
               state_in = S_MUL2;
            end
         end
         S_MUL2: begin
            prod_in  = mul_prod;
            state_in = S_ADD;
         end
         S_ADD: begin
            off_in   = {2'b0, prod_ff} + {hi_ns, 32'b0} + {34'b0, frac_ff};
            state_in = S_CHK;
         end
         S_CHK: begin
            deadline_in = sum[TIME_W-1:0];
            if (sum[64:63] != 2'b00) begin
               res_in.error = ERR_OVERFLOW;
               state_in     = S_PUSH;
            end else if (final_ff) begin
               // Limit reached: rebase only if this deadline has passed too
               if (due) begin
                  state_in = S_REB;
               end else begin
                  res_in.ticks_due = ticks_ff;
                  state_in         = S_PUSH;
               end
            end else if (!due) begin
               res_in.ticks_due = ticks_ff;
               state_in         = S_PUSH;
            end else if (ordinal_ff == {ORD_W{1'b1}}) begin
               res_in.error = ERR_OVERFLOW;
               state_in     = S_PUSH;
            end else begin
               ticks_in   = ticks_ff + 1'b1;
               ordinal_in = ordinal_ff + 1'b1;
               final_in   = ((ticks_ff + 1'b1) == limit_eff);
               state_in   = S_D1GO;
            end
         end
         S_REB: begin
            res_in.ticks_due   = ticks_ff;
            res_in.rebased     = 1'b1;
            res_in.lateness_ns = now_ff - deadline_ff;
            epoch_in           = now_ff;
            ordinal_in         = ORD_W'(1);
            state_in           = S_PUSH;
         end
         S_PUSH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         started_ff      <= 1'b0;
         epoch_ff        <= '0;
         ordinal_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         tick_rate_ff    <= TICK_RATE_RESET;
         max_catch_up_ff <= MAX_CATCH_UP_RESET;
         ticks_ff        <= '0;
         final_ff        <= 1'b0;
      end else begin
         state_ff        <= state_in;
         started_ff      <= started_in;
         epoch_ff        <= epoch_in;
         ordinal_ff      <= ordinal_in;
         rsp_valid_ff    <= rsp_valid_in;
         tick_rate_ff    <= tick_rate_in;
         max_catch_up_ff <= max_catch_up_in;
         ticks_ff        <= ticks_in;
         final_ff        <= final_in;
      end
      now_ff      <= now_in;
      whole_ff    <= whole_in;
      frac_ff     <= frac_in;
      prod_ff     <= prod_in;
      off_ff      <= off_in;
      deadline_ff <= deadline_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_div_start_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_D1WAIT || state_ff == S_D2WAIT))
      else $error("divider result arrived outside a wait state");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.error != ERR_OK) |->
         (rsp_data_ff.ticks_due == '0 && !rsp_data_ff.rebased &&
          rsp_data_ff.lateness_ns == '0))
      else $error("failing item carries tick data");

   a_started_sticky: assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("started flag dropped");

   a_ordinal_live: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> (ordinal_ff != '0))
      else $error("ordinal wrapped to zero");

endmodule

`default_nettype wire

@@ tb/tb_fixed_rate_tick_scheduler_core.sv @@
`default_nettype none

module tb_fixed_rate_tick_scheduler_core;
   import ftsch_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] SEC_NS      = 64'd1000000000;
   localparam logic [63:0] TIME_LIMIT  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] WHOLE_LIMIT = TIME_LIMIT / SEC_NS;
   localparam int          HOLD_CYCLES = 2000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wen = 1'b0;
   logic [0:0]       csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   fixed_rate_tick_scheduler_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Commands waiting to be offered, results waiting to be seen
   req_type cmd_pending_q[$];
   rsp_type tick_expect_q[$];

   // Scheduler shadow: configuration and schedule state
   logic [RATE_W-1:0]  cfg_rate  = TICK_RATE_RESET;
   logic [LIMIT_W-1:0] cfg_limit = MAX_CATCH_UP_RESET;
   logic               sched_started = 1'b0;
   logic [63:0]        sched_epoch   = '0;
   logic [ORD_W-1:0]   sched_ordinal = '0;

   int      send_gap_pct   = 8;
   int      recv_stall_pct = 55;
   int      hold_asks      = 0;
   int      hold_seen      = 0;
   int      hold_left      = 0;
   int      fail_count     = 0;
   logic    req_fire       = 1'b0;
   logic [TIME_W-1:0] t_base;

   initial begin
      forever #4 clock = ~clock;
   end

   // Deadline of the current ordinal; returns 0 when it would not fit in 63 bits
   function automatic bit sched_deadline(output logic [63:0] dl);
      logic [63:0] rate, whole, rem, frac, offs;
      rate  = (cfg_rate == '0) ? 64'd1 : {{(64-RATE_W){1'b0}}, cfg_rate};
      whole = sched_ordinal / rate;
      rem   = sched_ordinal % rate;
      frac  = (SEC_NS * rem) / rate;
      dl    = '0;
      if (whole > WHOLE_LIMIT)
         return 1'b0;
      offs = whole * SEC_NS + frac;
      if (offs > TIME_LIMIT - sched_epoch)
         return 1'b0;
      dl = sched_epoch + offs;
      return 1'b1;
   endfunction

   // Result of one command; updates the shadow schedule
   function automatic rsp_type sched_predict(input req_type cmd);
      rsp_type     r;
      logic [63:0] now, dl, lim, ticks, late;
      bit          counting;
      r        = '0;
      r.error  = ERR_OK;
      now      = {1'b0, cmd.now_ns};
      lim      = (cfg_limit == '0) ? 64'd1 : {{(64-LIMIT_W){1'b0}}, cfg_limit};
      ticks    = '0;
      counting = 1'b1;
      if (cmd.action == ACT_START) begin
         if (sched_started) begin
            r.error = ERR_ALREADY_STARTED;
         end else begin
            sched_started = 1'b1;
            sched_epoch   = now;
            sched_ordinal = 64'd1;
         end
         return r;
      end
      if (!sched_started) begin
         r.error = ERR_NOT_STARTED;
         return r;
      end
      // count passed deadlines up to the catch-up limit
      while (counting && ticks < lim) begin
         if (!sched_deadline(dl)) begin
            r.error = ERR_OVERFLOW;
            return r;
         end
         if (dl > now) begin
            counting = 1'b0;
         end else begin
            ticks = ticks + 64'd1;
            if (sched_ordinal == {ORD_W{1'b1}}) begin
               r.error = ERR_OVERFLOW;
               return r;
            end
            sched_ordinal = sched_ordinal + 64'd1;
         end
      end
      if (!sched_deadline(dl)) begin
         r.error = ERR_OVERFLOW;
         return r;
      end
      // limit hit and still behind: rebase on now
      if (ticks == lim && dl <= now) begin
         late          = now - dl;
         r.rebased     = 1'b1;
         r.lateness_ns = late[TIME_W-1:0];
         sched_epoch   = now;
         sched_ordinal = 64'd1;
      end
      r.ticks_due = ticks[LIMIT_W-1:0];
      return r;
   endfunction

   task automatic note_fail(input string what, input rsp_type e, input rsp_type g);
      fail_count++;
      if (fail_count <= 10)
         $display("%s: exp ticks=%0d rebased=%0d late=%0d err=%0d | got ticks=%0d rebased=%0d late=%0d err=%0d",
                  what, e.ticks_due, e.rebased, e.lateness_ns, e.error,
                  g.ticks_due, g.rebased, g.lateness_ns, g.error);
   endtask

   // Command driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (cmd_pending_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
            req_data  <= cmd_pending_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Monitor: predict on accepted commands, check accepted results
   always @(posedge clock) begin : monitor
      rsp_type exp_r;
      req_fire <= !reset && req_valid && !req_stall;
      if (reset) begin
         sched_started = 1'b0;
         sched_epoch   = '0;
         sched_ordinal = '0;
      end else begin
         if (req_valid && !req_stall)
            tick_expect_q.push_back(sched_predict(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (tick_expect_q.size() == 0) begin
               note_fail("unexpected result", '0, rsp_data);
            end else begin
               exp_r = tick_expect_q.pop_front();
               if (rsp_data.ticks_due !== exp_r.ticks_due ||
                   rsp_data.rebased !== exp_r.rebased ||
                   rsp_data.lateness_ns !== exp_r.lateness_ns ||
                   rsp_data.error !== exp_r.error)
                  note_fail("mismatch", exp_r, rsp_data);
            end
         end
      end
   end

   function automatic logic [TIME_W-1:0] rand63();
      logic [63:0] v;
      v = {$urandom(), $urandom()};
      return v[TIME_W-1:0];
   endfunction

   task automatic add_cmd(input logic act, input logic [TIME_W-1:0] t);
      req_type c;
      c.action = act;
      c.now_ns = t;
      cmd_pending_q.push_back(c);
   endtask

   // Block is idle once nothing is queued, offered or outstanding; looked at on
   // the rising edge so that the driver's last change has settled
   task automatic wait_idle();
      @(posedge clock);
      while (cmd_pending_q.size() != 0 || req_valid || tick_expect_q.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == REG_TICK_RATE)
         cfg_rate = val[RATE_W-1:0];
      else
         cfg_limit = val[LIMIT_W-1:0];
   endtask

   task automatic set_config(input logic [RATE_W-1:0] rate, input logic [LIMIT_W-1:0] lim);
      wait_idle();
      write_reg(REG_TICK_RATE, rate);
      write_reg(REG_MAX_CATCH_UP, {{(CSR_W-LIMIT_W){1'b0}}, lim});
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   // Mostly in-order advances sized to the tick period, with some noise
   task automatic run_random(input int n, input bit with_hold);
      logic [63:0] rate64, period, delta;
      int          lim;
      int          pick;
      rate64 = (cfg_rate == '0) ? 64'd1 : {{(64-RATE_W){1'b0}}, cfg_rate};
      period = SEC_NS / rate64;
      lim    = (cfg_limit == '0) ? 1 : int'(cfg_limit);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            delta  = period * 64'($urandom_range(0, lim + 2))
                   + 64'($urandom_range(0, period[31:0]));
            t_base = t_base + delta[TIME_W-1:0];
            add_cmd(ACT_ADVANCE, t_base);
         end else if (pick < 87) begin
            add_cmd(ACT_ADVANCE, t_base - TIME_W'($urandom_range(0, 1000000000)));
         end else if (pick < 93) begin
            add_cmd(ACT_START, rand63());
         end else begin
            t_base = t_base + TIME_W'({$urandom(), 4'd0});
            add_cmd(ACT_ADVANCE, t_base);
         end
      end
      if (with_hold)
         hold_asks++;
   endtask

   task automatic random_config();
      logic [RATE_W-1:0]  rate;
      logic [LIMIT_W-1:0] lim;
      case ($urandom_range(0, 4))
         0: rate = 20'd1;
         1: rate = RATE_W'($urandom_range(2, 100));
         2: rate = RATE_W'($urandom_range(101, 1000000));
         3: rate = RATE_W'($urandom_range(1000001, 1048575));
         default: rate = '0;
      endcase
      lim = LIMIT_W'($urandom_range(0, 16));
      set_config(rate, lim);
   endtask

   // Run timeout
   initial begin
      #100ms;
      $display("tb_fixed_rate_tick_scheduler_core NOT OK");
      $finish;
   end

   initial begin : stimulus
      logic [TIME_W-1:0] t0, ep, jump;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset settings of 30 ticks/s, catch-up of 5
      t0 = 63'd1000;
      ep = t0 + 63'd1000000000;
      add_cmd(ACT_ADVANCE, '0);                    // advance before start
      add_cmd(ACT_ADVANCE, TIME_LIMIT[TIME_W-1:0]);
      add_cmd(ACT_START, t0);
      add_cmd(ACT_START, 63'd5000);                // second start
      add_cmd(ACT_ADVANCE, t0);                    // nothing due yet
      add_cmd(ACT_ADVANCE, t0 + 63'd33333333);     // exactly on the first deadline
      add_cmd(ACT_ADVANCE, t0 + 63'd66666665);     // one ns short of the next
      add_cmd(ACT_ADVANCE, ep);                    // limit hit, rebase
      add_cmd(ACT_ADVANCE, ep + 63'd166666666);    // limit hit, next one not due
      add_cmd(ACT_ADVANCE, ep);                    // time went backward
      jump = 63'h4000_0000_0000_0000 | (rand63() & 63'h1FFF_FFFF_FFFF_FFFF);
      add_cmd(ACT_ADVANCE, jump);                  // huge lateness

      // Zero rate and zero catch-up act as one
      set_config('0, '0);
      add_cmd(ACT_ADVANCE, jump + 63'd1000000000);
      add_cmd(ACT_ADVANCE, jump + 63'd5000000000);
      ep = jump + 63'd5000000000;
      add_cmd(ACT_ADVANCE, ep + 63'd999999999);

      // Fastest rate, largest catch-up
      set_config(20'hFFFFF, 8'd255);
      add_cmd(ACT_ADVANCE, ep + 63'd300000);
      ep = ep + 63'd300000;
      add_cmd(ACT_ADVANCE, ep + 63'd100000);
      t_base = ep + 63'd100000;

      // Random: sender rarely idle, receiver often stalled; long hold-off first
      random_config();
      run_random(20, 1'b1);
      random_config();
      run_random(20, 1'b0);

      // Sender often idle, receiver rarely stalled
      wait_idle();
      send_gap_pct   = 55;
      recv_stall_pct = 8;
      random_config();
      run_random(20, 1'b0);
      random_config();
      run_random(20, 1'b0);

      // No idling at all
      wait_idle();
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      random_config();
      run_random(20, 1'b0);
      random_config();
      run_random(20, 1'b0);

      // Near the top of the time range: deadline overflow is permanent, so last
      set_config(20'hFFFFF, 8'd1);
      add_cmd(ACT_ADVANCE, TIME_LIMIT[TIME_W-1:0] - 63'd2500);
      set_config(20'hFFFFF, 8'd5);
      add_cmd(ACT_ADVANCE, TIME_LIMIT[TIME_W-1:0]); // two ticks kept, then overflow
      add_cmd(ACT_ADVANCE, TIME_LIMIT[TIME_W-1:0]);
      set_config(20'd1, 8'd1);
      add_cmd(ACT_ADVANCE, TIME_LIMIT[TIME_W-1:0]);

      wait_idle();
      repeat (64) @(negedge clock);
      if (fail_count == 0 && tick_expect_q.size() == 0)
         $display("tb_fixed_rate_tick_scheduler_core OK");
      else
         $display("tb_fixed_rate_tick_scheduler_core NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/ftsch_pkg.sv
rtl/ftsch_div.sv
rtl/fixed_rate_tick_scheduler_core.sv
tb/tb_fixed_rate_tick_scheduler_core.sv
